/* design/ast_pkg.sv */
// Shared types and constants for the action string tokenizer.
// Holds the classified token that travels from the front end to the parse engine.
// No dependencies.
package ast_pkg;

    // Width of the byte counter; the reported error position is 16 bits.
    localparam int POSITION_WIDTH = 16;
    localparam int ERRPOS_WIDTH   = 16;

    // Depth of the queue between the classifier and the parse engine.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_WIDTH  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

    // Special characters.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // The reserved key "data", one character per index.
    localparam logic [7:0] DATA_WORD [4] = '{8'h64, 8'h61, 8'h74, 8'h61};
    localparam logic [2:0] KEY_LEN_DATA = 3'd4;
    localparam logic [2:0] KEY_LEN_MAX  = 3'd5;

    // Byte roles.
    localparam logic [2:0] ROLE_DROP  = 3'd0;
    localparam logic [2:0] ROLE_TYPE  = 3'd1;
    localparam logic [2:0] ROLE_HASH  = 3'd2;
    localparam logic [2:0] ROLE_KEY   = 3'd3;
    localparam logic [2:0] ROLE_VALUE = 3'd4;

    // Field end markers.
    localparam logic [2:0] FEND_NONE  = 3'd0;
    localparam logic [2:0] FEND_TYPE  = 3'd1;
    localparam logic [2:0] FEND_HASH  = 3'd2;
    localparam logic [2:0] FEND_KEY   = 3'd3;
    localparam logic [2:0] FEND_VALUE = 3'd4;

    // Line status codes.
    localparam logic [3:0] ST_RUNNING    = 4'd0;
    localparam logic [3:0] ST_OK         = 4'd1;
    localparam logic [3:0] ST_NO_ATTRS   = 4'd2;
    localparam logic [3:0] ST_WS_KEY     = 4'd3;
    localparam logic [3:0] ST_DATA_KEY   = 4'd4;
    localparam logic [3:0] ST_NO_VALUE   = 4'd5;
    localparam logic [3:0] ST_QUOTE_KEY  = 4'd6;
    localparam logic [3:0] ST_NO_KEY     = 4'd7;
    localparam logic [3:0] ST_OPEN_QUOTE = 4'd8;

    // One input byte with its character class already decoded.
    typedef struct packed {
        logic [7:0] data;
        logic       eol;
        logic       is_ws;
        logic       is_sq;
        logic       is_dq;
        logic       is_eq;
        logic       is_bsl;
        logic       is_nul;
        logic [3:0] data_match;
    } t_token;

    // Handshake between the queue and its neighbors.
    typedef struct packed {
        logic push;
        logic pop;
    } t_queue_ctl;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_sts;

endpackage

/* design/ast_in_if.sv */
// Input channel of the action string tokenizer: one byte of the line per transfer.
// No dependencies.
interface ast_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_line;

    modport source (output valid, output data_byte, output end_of_line, input ready);
    modport sink   (input valid, input data_byte, input end_of_line, output ready);
endinterface

/* design/ast_out_if.sv */
// Output channel of the action string tokenizer: one tagged byte per transfer.
// No dependencies.
interface ast_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [2:0]  byte_role;
    logic        lead_backslash;
    logic [2:0]  field_end;
    logic [3:0]  status;
    logic [15:0] error_position;
    logic        line_done;

    modport source (
        output valid, output out_byte, output byte_role, output lead_backslash,
        output field_end, output status, output error_position, output line_done,
        input ready
    );
    modport sink (
        input valid, input out_byte, input byte_role, input lead_backslash,
        input field_end, input status, input error_position, input line_done,
        output ready
    );
endinterface

/* design/ast_front.sv */
// Front end of the tokenizer: accepts input bytes and decodes their character class.
// Depends on ast_pkg and ast_in_if.
module ast_front
    import ast_pkg::*;
(
    ast_in_if.sink       i_in,
    input  t_queue_sts   i_qsts,
    output logic         o_push,
    output t_token       o_token
);

    always_comb begin
        o_token.data   = i_in.data_byte;
        o_token.eol    = i_in.end_of_line;
        o_token.is_ws  = (i_in.data_byte == CH_SPACE) || (i_in.data_byte == CH_TAB);
        o_token.is_sq  = (i_in.data_byte == CH_SQ);
        o_token.is_dq  = (i_in.data_byte == CH_DQ);
        o_token.is_eq  = (i_in.data_byte == CH_EQ);
        o_token.is_bsl = (i_in.data_byte == CH_BSL);
        o_token.is_nul = (i_in.data_byte == CH_NUL);
        for (int k = 0; k < 4; k++) begin
            o_token.data_match[k] = (i_in.data_byte == DATA_WORD[k]);
        end
    end

    assign i_in.ready = !i_qsts.full;
    assign o_push     = i_in.valid && !i_qsts.full;

endmodule

/* design/ast_queue.sv */
// Short first-in first-out queue of decoded tokens between front end and parse engine.
// Depends on ast_pkg.
module ast_queue
    import ast_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_queue_ctl i_ctl,
    input  t_token     i_token,
    output t_token     o_token,
    output t_queue_sts o_sts
);

    t_token                r_mem [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0] r_wr_ptr;
    logic [QPTR_WIDTH-1:0] r_rd_ptr;
    logic [QCNT_WIDTH-1:0] r_count;

    function automatic logic [QPTR_WIDTH-1:0] ptr_next(input logic [QPTR_WIDTH-1:0] p);
        return (p == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_sts.full  = (r_count == QCNT_WIDTH'(QUEUE_DEPTH));
    assign o_sts.empty = (r_count == '0);
    assign o_token     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_ctl.push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (i_ctl.pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            case ({i_ctl.push, i_ctl.pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // The neighbors must never push into a full queue or pop an empty one.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctl.push && o_sts.full && !i_ctl.pop))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctl.pop && o_sts.empty))
        else $error("queue pop while empty");

endmodule

/* design/ast_back.sv */
// Parse engine of the tokenizer: walks the line state machine over decoded tokens
// and holds the output register. Depends on ast_pkg and ast_out_if.
module ast_back
    import ast_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_token     i_token,
    input  t_queue_sts i_qsts,
    output logic       o_pop,
    ast_out_if.source  o_out
);

    typedef enum logic [2:0] {
        PH_TYPE, PH_WS, PH_KEY, PH_EQ, PH_UQ, PH_QV, PH_QESC, PH_DONE
    } t_phase;

    localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

    t_phase                    r_phase,  n_phase;
    logic                      r_qd,     n_qd;
    logic                      r_hash,   n_hash;
    logic                      r_attr,   n_attr;
    logic [2:0]                r_klen,   n_klen;
    logic                      r_kdata,  n_kdata;
    logic [POSITION_WIDTH-1:0] r_pos,    n_pos;
    logic [3:0]                r_status, n_status;

    logic                      r_ovalid;
    logic [7:0]                r_obyte;
    logic [2:0]                r_orole;
    logic                      r_olead;
    logic [2:0]                r_ofend;
    logic [3:0]                r_ostatus;
    logic [ERRPOS_WIDTH-1:0]   r_oerr;
    logic                      r_oeol;

    logic [2:0]                role, fend;
    logic                      lead, raised, do_fin;
    t_phase                    fin_phase;
    logic [POSITION_WIDTH-1:0] fin_pos, pos_inc;
    logic [3:0]                res_status;
    logic [31:0]               err_ext;
    logic                      is_quote, key_role;

    assign o_pop   = !i_qsts.empty && (!r_ovalid || o_out.ready);
    assign pos_inc = (r_pos == POS_MAX) ? r_pos : r_pos + 1'b1;
    assign is_quote = r_qd ? i_token.is_dq : i_token.is_sq;
    assign key_role = r_hash || r_attr;

    always_comb begin
        n_phase   = r_phase;
        n_qd      = r_qd;
        n_hash    = r_hash;
        n_attr    = r_attr;
        n_klen    = r_klen;
        n_kdata   = r_kdata;
        n_pos     = r_pos;
        n_status  = r_status;
        role      = ROLE_DROP;
        fend      = FEND_NONE;
        lead      = 1'b0;
        raised    = 1'b0;
        do_fin    = 1'b0;
        fin_phase = r_phase;
        fin_pos   = r_pos;

        if (r_phase == PH_DONE) begin
            // Status already decided: the byte is dropped.
        end else if (i_token.is_nul) begin
            do_fin    = 1'b1;
            fin_phase = r_phase;
            fin_pos   = r_pos;
        end else begin
            unique case (r_phase)
                PH_TYPE: begin
                    if (i_token.is_ws) begin
                        fend    = FEND_TYPE;
                        n_phase = PH_WS;
                    end else begin
                        role = ROLE_TYPE;
                    end
                end
                PH_WS: begin
                    if (i_token.is_ws) begin
                        n_phase = PH_WS;
                    end else if (i_token.is_eq) begin
                        n_phase  = PH_DONE;
                        n_status = ST_NO_KEY;
                        raised   = 1'b1;
                    end else begin
                        n_phase = PH_KEY;
                        n_klen  = 3'd1;
                        n_kdata = i_token.data_match[0];
                        role    = key_role ? ROLE_KEY : ROLE_HASH;
                    end
                end
                PH_KEY: begin
                    if (i_token.is_ws) begin
                        if (key_role) begin
                            n_phase  = PH_DONE;
                            n_status = ST_WS_KEY;
                            raised   = 1'b1;
                        end else begin
                            n_hash  = 1'b1;
                            fend    = FEND_HASH;
                            n_phase = PH_WS;
                        end
                    end else if (i_token.is_eq) begin
                        if (r_klen == KEY_LEN_DATA && r_kdata) begin
                            n_phase  = PH_DONE;
                            n_status = ST_DATA_KEY;
                            raised   = 1'b1;
                        end else begin
                            fend    = FEND_KEY;
                            n_attr  = 1'b1;
                            n_phase = PH_EQ;
                        end
                    end else if (i_token.is_sq || i_token.is_dq) begin
                        n_phase  = PH_DONE;
                        n_status = ST_QUOTE_KEY;
                        raised   = 1'b1;
                    end else begin
                        role = key_role ? ROLE_KEY : ROLE_HASH;
                        if (r_klen < KEY_LEN_DATA && !i_token.data_match[r_klen[1:0]]) begin
                            n_kdata = 1'b0;
                        end
                        if (r_klen < KEY_LEN_MAX) begin
                            n_klen = r_klen + 1'b1;
                        end
                    end
                end
                PH_EQ: begin
                    if (i_token.is_sq || i_token.is_dq) begin
                        n_qd    = i_token.is_dq;
                        n_phase = PH_QV;
                    end else if (i_token.is_ws) begin
                        n_phase  = PH_DONE;
                        n_status = ST_NO_VALUE;
                        raised   = 1'b1;
                    end else begin
                        role    = ROLE_VALUE;
                        n_phase = PH_UQ;
                    end
                end
                PH_UQ: begin
                    if (i_token.is_ws) begin
                        fend    = FEND_VALUE;
                        n_phase = PH_WS;
                    end else begin
                        role = ROLE_VALUE;
                    end
                end
                PH_QV: begin
                    if (i_token.is_bsl) begin
                        if (i_token.eol) begin
                            n_phase  = PH_DONE;
                            n_status = ST_OPEN_QUOTE;
                            raised   = 1'b1;
                        end else begin
                            n_phase = PH_QESC;
                        end
                    end else if (is_quote) begin
                        fend    = FEND_VALUE;
                        n_phase = PH_WS;
                    end else begin
                        role = ROLE_VALUE;
                    end
                end
                PH_QESC: begin
                    // A held backslash is dropped before a backslash or the quote.
                    n_phase = PH_QV;
                    role    = ROLE_VALUE;
                    lead    = !(i_token.is_bsl || is_quote);
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase
            if (i_token.eol && n_phase != PH_DONE) begin
                do_fin    = 1'b1;
                fin_phase = n_phase;
                fin_pos   = pos_inc;
            end
        end

        // The line ended: settle the status from the phase it ended in.
        if (do_fin) begin
            n_phase = PH_DONE;
            case (fin_phase)
                PH_TYPE: begin
                    n_status = ST_NO_ATTRS;
                    n_pos    = fin_pos;
                    raised   = 1'b1;
                end
                PH_KEY, PH_EQ: begin
                    n_status = ST_NO_VALUE;
                    n_pos    = fin_pos;
                    raised   = 1'b1;
                end
                PH_QV: begin
                    n_status = ST_OPEN_QUOTE;
                    n_pos    = fin_pos;
                    raised   = 1'b1;
                end
                PH_QESC: begin
                    n_status = ST_OPEN_QUOTE;
                    n_pos    = (fin_pos != '0) ? fin_pos - 1'b1 : '0;
                    raised   = 1'b1;
                end
                PH_UQ: begin
                    fend     = FEND_VALUE;
                    n_status = ST_OK;
                    n_pos    = r_pos;
                end
                default: begin
                    n_status = ST_OK;
                    n_pos    = r_pos;
                end
            endcase
        end else if (raised) begin
            n_pos = r_pos;
        end

        if (n_phase != PH_DONE) begin
            n_pos = pos_inc;
        end

        if (raised) begin
            role = ROLE_DROP;
            fend = FEND_NONE;
            lead = 1'b0;
        end
    end

    assign res_status = (n_phase == PH_DONE) ? n_status : ST_RUNNING;
    assign err_ext    = 32'(n_pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_TYPE;
            r_qd     <= 1'b0;
            r_hash   <= 1'b0;
            r_attr   <= 1'b0;
            r_klen   <= '0;
            r_kdata  <= 1'b1;
            r_pos    <= '0;
            r_status <= ST_RUNNING;
            r_ovalid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_ovalid  <= 1'b1;
                r_obyte   <= i_token.data;
                r_orole   <= role;
                r_olead   <= lead;
                r_ofend   <= fend;
                r_ostatus <= res_status;
                r_oerr    <= (res_status >= ST_NO_ATTRS) ? err_ext[ERRPOS_WIDTH-1:0] : '0;
                r_oeol    <= i_token.eol;
                if (i_token.eol) begin
                    r_phase  <= PH_TYPE;
                    r_qd     <= 1'b0;
                    r_hash   <= 1'b0;
                    r_attr   <= 1'b0;
                    r_klen   <= '0;
                    r_kdata  <= 1'b1;
                    r_pos    <= '0;
                    r_status <= ST_RUNNING;
                end else begin
                    r_phase  <= n_phase;
                    r_qd     <= n_qd;
                    r_hash   <= n_hash;
                    r_attr   <= n_attr;
                    r_klen   <= n_klen;
                    r_kdata  <= n_kdata;
                    r_pos    <= n_pos;
                    r_status <= n_status;
                end
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out.valid          = r_ovalid;
    assign o_out.out_byte       = r_obyte;
    assign o_out.byte_role      = r_orole;
    assign o_out.lead_backslash = r_olead;
    assign o_out.field_end      = r_ofend;
    assign o_out.status         = r_ostatus;
    assign o_out.error_position = r_oerr;
    assign o_out.line_done      = r_oeol;

    // A finished phase always carries a decided status.
    a_done_has_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE) |-> (r_status != ST_RUNNING))
        else $error("done phase without status");
    // The last byte of a line always reports a decided status.
    a_eol_decided: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_oeol) |-> (r_ostatus != ST_RUNNING))
        else $error("line ended without status");
    // After the last byte of a line the engine is back at the type phase.
    a_eol_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_token.eol) |=> (r_phase == PH_TYPE && r_pos == '0))
        else $error("engine not reset after line end");

endmodule

/* design/action_string_tokenizer.sv */
// Top level of the action string tokenizer: front end, token queue and parse engine.
// Depends on ast_pkg, ast_in_if, ast_out_if, ast_front, ast_queue and ast_back.
//
// The tokenizer takes an action line one byte per transfer and returns exactly one
// tagged result per byte. Bytes up to the first space or tab are the type; after
// that come an optional hash token and key=value attributes, where a value is bare
// or quoted with a single or double quote. Each result carries the byte, its role,
// whether a held backslash precedes it, which field ended on it, the line status
// and, for errors, the byte index where the error was found. Inside a quoted value
// a backslash is held back and removed when a backslash or the closing quote
// follows. Once a status is decided, the remaining bytes of the line are dropped,
// and the last byte of the line (end_of_line set) returns the engine to its reset
// state. A zero byte ends the line early. The block takes one byte every clock
// cycle while neither side stalls, and each byte passes through the token queue
// between the byte classifier and the parse engine and then through the output
// register. The parse engine advances one byte per cycle while a token waits and
// the output is free; the queue and the output register let either side stall without losing a byte.
module action_string_tokenizer
    import ast_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    ast_in_if.sink    i_in,
    ast_out_if.source o_out
);

    t_token     front_token;
    t_token     queue_token;
    t_queue_ctl qctl;
    t_queue_sts qsts;
    logic       push;
    logic       pop;

    // The front end decodes the character class of each byte on its way in.
    ast_front u_front (
        .i_in    (i_in),
        .i_qsts  (qsts),
        .o_push  (push),
        .o_token (front_token)
    );

    assign qctl.push = push;
    assign qctl.pop  = pop;

    // The queue decouples input acceptance from the parse engine.
    ast_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (qctl),
        .i_token (front_token),
        .o_token (queue_token),
        .o_sts   (qsts)
    );

    // The parse engine runs the line state machine and owns the output register.
    ast_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_token (queue_token),
        .i_qsts  (qsts),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

/* dv/testbench.sv */
// Self-checking testbench for action_string_tokenizer: directed lines and random action lines,
// checked byte by byte against a behavioral tokenizer kept in this file.
// Depends on ast_pkg, ast_in_if, ast_out_if and the action_string_tokenizer RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ast_pkg::*;

    // Stop random stimulus once this many random bytes have been sent.
    localparam int RANDOM_BYTES    = 500;
    // Cycles without any transfer on either side before the run is declared hung.
    localparam int WATCHDOG_LIMIT  = 2000;
    // Extra cycles after the last result.
    localparam int DRAIN_CYCLES    = 8;

    // Parse phases of the behavioral tokenizer. Once a status is decided it sits in PH_DONE
    // and the decided code is held separately.
    typedef enum logic [2:0] {
        PH_TYPE, PH_GAP, PH_KEY, PH_EQ, PH_BARE, PH_QUOTED, PH_ESC, PH_DONE
    } t_parse_phase;

    // One tagged byte as it leaves the block.
    typedef struct packed {
        logic [7:0]  out_byte;
        logic [2:0]  byte_role;
        logic        lead_backslash;
        logic [2:0]  field_end;
        logic [3:0]  status;
        logic [15:0] error_position;
        logic        line_done;
    } t_byte_tag;

    // One row of the directed table. Pinned rows carry a hand-written tag that is checked
    // instead of the predicted one.
    typedef struct {
        logic [7:0] data_byte;
        logic       end_of_line;
        logic       pinned;
        t_byte_tag  tag;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ast_in_if  byte_in();
    ast_out_if tag_out();

    action_string_tokenizer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_in),
        .o_out   (tag_out)
    );

    always #5ns i_clk = ~i_clk;

    // State of the behavioral tokenizer.
    t_parse_phase tok_phase;
    logic [3:0]   tok_status;
    logic         tok_dq;
    logic         tok_hash_seen;
    logic         tok_attr_seen;
    logic [2:0]   tok_key_len;
    logic         tok_key_data;
    logic [15:0]  tok_pos;

    t_byte_tag   expected_tags[$];
    t_stim_row   directed_rows[$];
    logic [7:0]  line_buf[$];

    int mismatch_count = 0;
    int sent_bytes     = 0;
    int burst_left     = 0;
    int stall_cycles   = 0;

    logic [15:0] stall_pattern;
    int          pattern_age;

    // ------------------------------------------------------------------------------------
    // Behavioral tokenizer
    // ------------------------------------------------------------------------------------

    function automatic void clear_tokenizer();
        tok_phase     = PH_TYPE;
        tok_status    = ST_RUNNING;
        tok_dq        = 1'b0;
        tok_hash_seen = 1'b0;
        tok_attr_seen = 1'b0;
        tok_key_len   = 3'd0;
        tok_key_data  = 1'b1;
        tok_pos       = 16'd0;
    endfunction

    // The byte counter sticks at its top value instead of wrapping.
    function automatic logic [15:0] next_pos(input logic [15:0] p);
        return (p == 16'hFFFF) ? p : p + 16'd1;
    endfunction

    // Freezes the line status and the position. Returns 1 when the status is an error, since
    // the byte that raises an error loses its role and field marker.
    function automatic logic settle(input logic [3:0] code, input logic [15:0] where);
        tok_phase  = PH_DONE;
        tok_status = code;
        tok_pos    = where;
        return code >= ST_NO_ATTRS;
    endfunction

    // End of line, either by end_of_line or by a zero byte: the phase decides the status.
    function automatic logic close_line(input logic [15:0] endpos, inout logic [2:0] fend);
        case (tok_phase)
            PH_TYPE:      return settle(ST_NO_ATTRS, endpos);
            PH_KEY, PH_EQ: return settle(ST_NO_VALUE, endpos);
            PH_QUOTED:    return settle(ST_OPEN_QUOTE, endpos);
            // A held backslash right before the end: the error points at the backslash.
            PH_ESC:       return settle(ST_OPEN_QUOTE, (endpos != 16'd0) ? endpos - 16'd1 : 16'd0);
            PH_BARE: begin
                fend = FEND_VALUE;
                return settle(ST_OK, tok_pos);
            end
            default:      return settle(ST_OK, tok_pos);
        endcase
    endfunction

    // Tags one accepted byte and advances the tokenizer state.
    function automatic t_byte_tag tokenize_byte(input logic [7:0] b, input logic eol);
        t_byte_tag   r;
        logic        raised;
        logic        ws;
        logic        isq;
        logic [7:0]  quote;
        logic [15:0] pos;
        logic [2:0]  role;
        logic [2:0]  fend;
        logic        lead;
        logic [3:0]  st;

        raised = 1'b0;
        ws     = (b == CH_SPACE) || (b == CH_TAB);
        isq    = (b == CH_SQ) || (b == CH_DQ);
        quote  = tok_dq ? CH_DQ : CH_SQ;
        pos    = tok_pos;
        role   = ROLE_DROP;
        fend   = FEND_NONE;
        lead   = 1'b0;
        st     = ST_RUNNING;

        if (tok_phase == PH_DONE) begin
            // Status already decided: the byte is dropped.
        end else if (b == CH_NUL) begin
            raised = close_line(pos, fend);
        end else begin
            case (tok_phase)
                PH_TYPE: begin
                    if (ws) begin
                        fend      = FEND_TYPE;
                        tok_phase = PH_GAP;
                    end else begin
                        role = ROLE_TYPE;
                    end
                end
                PH_GAP: begin
                    if (!ws) begin
                        if (b == CH_EQ) begin
                            raised = settle(ST_NO_KEY, pos);
                        end else begin
                            tok_phase    = PH_KEY;
                            tok_key_len  = 3'd1;
                            tok_key_data = (b == DATA_WORD[0]);
                            // The first token may still turn out to be the hash.
                            role = (tok_hash_seen || tok_attr_seen) ? ROLE_KEY : ROLE_HASH;
                        end
                    end
                end
                PH_KEY: begin
                    if (ws) begin
                        if (tok_hash_seen || tok_attr_seen) begin
                            raised = settle(ST_WS_KEY, pos);
                        end else begin
                            tok_hash_seen = 1'b1;
                            fend          = FEND_HASH;
                            tok_phase     = PH_GAP;
                        end
                    end else if (b == CH_EQ) begin
                        if (tok_key_len == KEY_LEN_DATA && tok_key_data) begin
                            raised = settle(ST_DATA_KEY, pos);
                        end else begin
                            fend          = FEND_KEY;
                            tok_attr_seen = 1'b1;
                            tok_phase     = PH_EQ;
                        end
                    end else if (isq) begin
                        raised = settle(ST_QUOTE_KEY, pos);
                    end else begin
                        role = (tok_hash_seen || tok_attr_seen) ? ROLE_KEY : ROLE_HASH;
                        if (tok_key_len < KEY_LEN_DATA && b != DATA_WORD[tok_key_len[1:0]])
                            tok_key_data = 1'b0;
                        if (tok_key_len < KEY_LEN_MAX)
                            tok_key_len = tok_key_len + 3'd1;
                    end
                end
                PH_EQ: begin
                    if (isq) begin
                        tok_dq    = (b == CH_DQ);
                        tok_phase = PH_QUOTED;
                    end else if (ws) begin
                        raised = settle(ST_NO_VALUE, pos);
                    end else begin
                        role      = ROLE_VALUE;
                        tok_phase = PH_BARE;
                    end
                end
                PH_BARE: begin
                    if (ws) begin
                        fend      = FEND_VALUE;
                        tok_phase = PH_GAP;
                    end else begin
                        role = ROLE_VALUE;
                    end
                end
                PH_QUOTED: begin
                    if (b == CH_BSL) begin
                        // A backslash cannot be held past the end of the line.
                        if (eol)
                            raised = settle(ST_OPEN_QUOTE, pos);
                        else
                            tok_phase = PH_ESC;
                    end else if (b == quote) begin
                        fend      = FEND_VALUE;
                        tok_phase = PH_GAP;
                    end else begin
                        role = ROLE_VALUE;
                    end
                end
                default: begin
                    // The held backslash vanishes before a backslash or the open quote and
                    // is released in front of anything else.
                    tok_phase = PH_QUOTED;
                    role      = ROLE_VALUE;
                    lead      = !(b == CH_BSL || b == quote);
                end
            endcase
            if (eol && tok_phase != PH_DONE)
                raised = close_line(next_pos(pos), fend) | raised;
        end

        if (tok_phase != PH_DONE)
            tok_pos = next_pos(tok_pos);
        else
            st = tok_status;

        if (raised) begin
            role = ROLE_DROP;
            fend = FEND_NONE;
            lead = 1'b0;
        end

        r.out_byte       = b;
        r.byte_role      = role;
        r.lead_backslash = lead;
        r.field_end      = fend;
        r.status         = st;
        r.error_position = (st >= ST_NO_ATTRS) ? tok_pos : 16'd0;
        r.line_done      = eol;

        if (eol)
            clear_tokenizer();
        return r;
    endfunction

    // ------------------------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------------------------

    function automatic t_byte_tag make_tag(input logic [7:0] b, input logic [2:0] role,
                                           input logic [2:0] fend, input logic [3:0] st,
                                           input logic [15:0] where, input logic done);
        t_byte_tag t;
        t.out_byte       = b;
        t.byte_role      = role;
        t.lead_backslash = 1'b0;
        t.field_end      = fend;
        t.status         = st;
        t.error_position = where;
        t.line_done      = done;
        return t;
    endfunction

    function automatic void add_row(input logic [7:0] b, input logic eol, input logic pinned,
                                    input t_byte_tag t);
        directed_rows.push_back('{b, eol, pinned, t});
    endfunction

    // Bytes of a text fragment, none of them the last of its line, checked by prediction.
    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_row(s[i], 1'b0, 1'b0, '0);
    endfunction

    function automatic void build_directed_table();
        // A type with nothing after it: no attributes, reported one past the last byte.
        add_row("t", 1'b1, 1'b1, make_tag("t", ROLE_DROP, FEND_NONE, ST_NO_ATTRS, 16'd1, 1'b1));
        // A zero byte as the whole line ends it at index zero.
        add_row(CH_NUL, 1'b1, 1'b1,
                make_tag(CH_NUL, ROLE_DROP, FEND_NONE, ST_NO_ATTRS, 16'd0, 1'b1));
        // An equals sign where a key should start; the byte after it is only dropped.
        add_text("t ");
        add_row(CH_EQ, 1'b0, 1'b1, make_tag(CH_EQ, ROLE_DROP, FEND_NONE, ST_NO_KEY, 16'd2, 1'b0));
        add_row(8'hFF, 1'b1, 1'b1, make_tag(8'hFF, ROLE_DROP, FEND_NONE, ST_NO_KEY, 16'd2, 1'b1));
        // Hash token, a key that starts with a quote, and a double-quoted value holding an
        // escaped backslash and a released backslash. The closing quote ends a good line.
        add_text("t h '=\"\\\\\\x");
        add_row(CH_DQ, 1'b1, 1'b1, make_tag(CH_DQ, ROLE_DROP, FEND_VALUE, ST_OK, 16'd0, 1'b1));
        // A zero byte right after a held backslash: the error points at the backslash.
        add_text("t k='\\");
        add_row(CH_NUL, 1'b1, 1'b1,
                make_tag(CH_NUL, ROLE_DROP, FEND_NONE, ST_OPEN_QUOTE, 16'd5, 1'b1));
    endfunction

    // ------------------------------------------------------------------------------------
    // Random action lines
    // ------------------------------------------------------------------------------------

    // A byte with no meaning to the parser, mostly printable.
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do begin
            if ($urandom_range(0, 3) == 0)
                c = 8'($urandom_range(1, 255));
            else
                c = 8'($urandom_range(33, 126));
        end while (c == CH_SPACE || c == CH_TAB || c == CH_EQ || c == CH_SQ || c == CH_DQ ||
                   c == CH_BSL);
        return c;
    endfunction

    function automatic logic [7:0] special_char();
        case ($urandom_range(0, 7))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_EQ;
            3:       return CH_SQ;
            4:       return CH_DQ;
            5:       return CH_BSL;
            6:       return CH_NUL;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void add_word(input int n);
        repeat (n) line_buf.push_back(plain_char());
    endfunction

    function automatic void add_gap();
        repeat ($urandom_range(1, 2)) line_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    endfunction

    function automatic void add_key();
        case ($urandom_range(0, 11))
            0: for (int j = 0; j < 4; j++) line_buf.push_back(DATA_WORD[j]);
            1: begin
                // A proper prefix of the reserved key, sometimes followed by other bytes.
                for (int j = 0; j < int'($urandom_range(1, 3)); j++)
                    line_buf.push_back(DATA_WORD[j]);
                if ($urandom_range(0, 1)) add_word(1);
            end
            2: begin
                for (int j = 0; j < 4; j++) line_buf.push_back(DATA_WORD[j]);
                add_word($urandom_range(1, 2));
            end
            3: begin
                line_buf.push_back($urandom_range(0, 1) ? CH_SQ : CH_DQ);
                add_word($urandom_range(0, 3));
            end
            4: ;  // no key at all
            default: add_word($urandom_range(1, 7));
        endcase
    endfunction

    // Appends a value after the equals sign. Returns 1 when the line is left open inside a
    // quoted value, so that nothing may follow it.
    function automatic logic add_value();
        logic [7:0] q;
        logic [7:0] other;
        case ($urandom_range(0, 9))
            0: return 1'b0;  // empty value
            1, 2, 3: begin
                add_word($urandom_range(1, 4));
                return 1'b0;
            end
            default: begin
                q     = $urandom_range(0, 1) ? CH_SQ : CH_DQ;
                other = (q == CH_SQ) ? CH_DQ : CH_SQ;
                line_buf.push_back(q);
                repeat ($urandom_range(0, 6)) begin
                    case ($urandom_range(0, 7))
                        0: begin
                            line_buf.push_back(CH_BSL);
                            case ($urandom_range(0, 3))
                                0:       line_buf.push_back(CH_BSL);
                                1:       line_buf.push_back(q);
                                2:       line_buf.push_back(other);
                                default: line_buf.push_back(plain_char());
                            endcase
                        end
                        1:       line_buf.push_back(other);
                        2:       line_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_EQ);
                        default: line_buf.push_back(plain_char());
                    endcase
                end
                if ($urandom_range(0, 11) == 0) begin
                    if ($urandom_range(0, 1)) line_buf.push_back(CH_BSL);
                    return 1'b1;
                end
                line_buf.push_back(q);
                return 1'b0;
            end
        endcase
    endfunction

    // Mostly well-formed lines with random content; a quarter are damaged or pure noise.
    function automatic void build_line();
        int kind;
        int n_attr;
        int cut;
        kind = $urandom_range(0, 99);
        line_buf.delete();
        add_word($urandom_range(1, 3));
        if (kind < 5) begin
            if ($urandom_range(0, 1)) add_gap();
            return;
        end
        add_gap();
        if ($urandom_range(0, 2) == 0) begin
            add_word($urandom_range(1, 4));
            add_gap();
        end
        // A second bare token after the hash, when there is one, is whitespace in a key.
        if ($urandom_range(0, 19) == 0) begin
            add_word($urandom_range(1, 3));
            add_gap();
        end
        n_attr = $urandom_range(1, 3);
        for (int i = 0; i < n_attr; i++) begin
            add_key();
            line_buf.push_back(CH_EQ);
            if (add_value()) break;
            if (i < n_attr - 1 || $urandom_range(0, 4) == 0) add_gap();
        end
        if (kind >= 75) begin
            case ($urandom_range(0, 3))
                0: line_buf.insert($urandom_range(0, line_buf.size()), special_char());
                1: begin
                    cut = $urandom_range(0, line_buf.size() - 1);
                    line_buf = line_buf[0:cut];
                end
                2: begin
                    line_buf.delete();
                    repeat ($urandom_range(1, 12))
                        line_buf.push_back(($urandom_range(0, 2) == 0) ? special_char()
                                                                       : 8'($urandom_range(0, 255)));
                end
                default: line_buf.insert($urandom_range(0, line_buf.size() - 1), CH_NUL);
            endcase
        end
    endfunction

    // ------------------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------------------

    // Offers one byte and waits for its transfer. The expected tag is queued at the transfer
    // edge. The sender works in bursts; after a burst valid is lowered and held low for a
    // randomly drawn gap before the next byte is offered.
    task automatic send_byte(input logic [7:0] b, input logic eol, input logic pinned,
                             input t_byte_tag pinned_tag);
        t_byte_tag predicted;
        byte_in.valid       <= 1'b1;
        byte_in.data_byte   <= b;
        byte_in.end_of_line <= eol;
        do @(posedge i_clk); while (!byte_in.ready);
        sent_bytes++;
        predicted = tokenize_byte(b, eol);
        expected_tags.push_back(pinned ? pinned_tag : predicted);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            byte_in.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // Holds the sender off until every expected tag has come back.
    task automatic hold_off();
        byte_in.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_tags.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------------------
    // Receiver: ready follows a rotating pattern that is redrawn now and then. A quarter of
    // the patterns are all ones, which gives stretches without stalls. Every pattern holds
    // at least one set bit, so ready never stays low for more than a rotation.
    // ------------------------------------------------------------------------------------

    always @(posedge i_clk) begin
        tag_out.ready <= stall_pattern[0];
        if (pattern_age == 0) begin
            stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                         : (16'($urandom) | 16'h0001);
            pattern_age   <= $urandom_range(16, 96);
        end else begin
            stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
            pattern_age   <= pattern_age - 1;
        end
    end

    // ------------------------------------------------------------------------------------
    // Result checker: each output transfer is compared field by field with the oldest
    // expected tag.
    // ------------------------------------------------------------------------------------

    always @(posedge i_clk) begin : check_tags
        t_byte_tag got;
        t_byte_tag want;
        logic      bad;
        if (i_rst_n && tag_out.valid && tag_out.ready) begin
            got.out_byte       = tag_out.out_byte;
            got.byte_role      = tag_out.byte_role;
            got.lead_backslash = tag_out.lead_backslash;
            got.field_end      = tag_out.field_end;
            got.status         = tag_out.status;
            got.error_position = tag_out.error_position;
            got.line_done      = tag_out.line_done;
            if (expected_tags.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result with nothing expected: byte %02h role %0d status %0d",
                             $realtime, got.out_byte, got.byte_role, got.status);
            end else begin
                want = expected_tags.pop_front();
                bad  = (got.out_byte       !== want.out_byte)       ||
                       (got.byte_role      !== want.byte_role)      ||
                       (got.lead_backslash !== want.lead_backslash) ||
                       (got.field_end      !== want.field_end)      ||
                       (got.status         !== want.status)         ||
                       (got.error_position !== want.error_position) ||
                       (got.line_done      !== want.line_done);
                if (bad) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $write("%0t: mismatch: expected byte %02h role %0d lead %0d end %0d ",
                               $realtime, want.out_byte, want.byte_role,
                               want.lead_backslash, want.field_end);
                        $write("status %0d pos %0d done %0d, ", want.status,
                               want.error_position, want.line_done);
                        $write("got byte %02h role %0d lead %0d end %0d ", got.out_byte,
                               got.byte_role, got.lead_backslash, got.field_end);
                        $display("status %0d pos %0d done %0d", got.status,
                                 got.error_position, got.line_done);
                    end
                end
            end
        end
    end

    // Watchdog: a long run of cycles with no transfer on either side means the block hung.
    always @(posedge i_clk) begin
        if ((byte_in.valid && byte_in.ready) || (tag_out.valid && tag_out.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL action_string_tokenizer");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------------------

    initial begin
        byte_in.valid       = 1'b0;
        byte_in.data_byte   = 8'h00;
        byte_in.end_of_line = 1'b0;
        tag_out.ready       = 1'b0;
        stall_pattern       = 16'hFFFF;
        pattern_age         = 0;
        i_rst_n             = 1'b0;
        clear_tokenizer();
        build_directed_table();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: walk the table.
        foreach (directed_rows[i])
            send_byte(directed_rows[i].data_byte, directed_rows[i].end_of_line,
                      directed_rows[i].pinned, directed_rows[i].tag);
        hold_off();

        // Random lines until enough bytes have been sent.
        sent_bytes = 0;
        while (sent_bytes < RANDOM_BYTES) begin
            build_line();
            foreach (line_buf[i])
                send_byte(line_buf[i], i == line_buf.size() - 1, 1'b0, '0);
            if ($urandom_range(0, 9) == 0) hold_off();
        end

        byte_in.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_tags.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && expected_tags.size() == 0)
            $display("PASS action_string_tokenizer");
        else
            $display("FAIL action_string_tokenizer");
        $finish;
    end

endmodule
